>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the byte-pair expander RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define BPE_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("bpe invariant violated");

// consequent holds in the cycle after the antecedent
`define BPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpe next-cycle check violated");

`endif

>>> hdl/bpe_pkg.sv
// ----------------------------------------------------------------------------
// bpe_pkg
// Types, codes and the symbol extraction helper of the byte-pair expander.
// ----------------------------------------------------------------------------
package bpe_pkg;

  // item function codes
  localparam logic [1:0] FUNC_SUPPLY = 2'd0;
  localparam logic [1:0] FUNC_PULL   = 2'd1;
  localparam logic [1:0] FUNC_START  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_NEED  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // configuration register indexes
  localparam logic CFG_WIDE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] word;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
  } out_item_t;

  // decoder phase
  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_HEAD   = 8'b0000_0010,
    PH_LEFT   = 8'b0000_0100,
    PH_RIGHT  = 8'b0000_1000,
    PH_COUNT  = 8'b0001_0000,
    PH_DECODE = 8'b0010_0000,
    PH_DONE   = 8'b0100_0000,
    PH_ERROR  = 8'b1000_0000
  } phase_t;

  // sequencer state
  typedef enum logic [5:0] {
    C_WAIT  = 6'b00_0001,
    C_RUN   = 6'b00_0010,
    C_SKIP  = 6'b00_0100,
    C_POP   = 6'b00_1000,
    C_CHASE = 6'b01_0000,
    C_EMIT  = 6'b10_0000
  } ctl_t;

  typedef struct packed {
    logic        ok;
    logic        used;
    logic [7:0]  sym;
    logic [31:0] bbuf;
    logic [5:0]  cnt;
  } take_t;

  // pull one symbol from the bit buffer, refilling from the held word
  function automatic take_t take_symbol(logic [31:0] bbuf, logic [5:0] cnt,
                                        logic [15:0] held, logic hv, logic wide);
    take_t       r;
    logic [31:0] b;
    logic [5:0]  c;
    r    = '0;
    b    = bbuf;
    c    = cnt;
    r.ok = 1'b1;
    if (c < 6'd16) begin
      if (!hv) begin
        r.ok = 1'b0;
      end else begin
        b      = b | ({16'b0, held} << c);
        c      = c + 6'd16;
        r.used = 1'b1;
      end
    end
    if (wide) begin
      r.sym  = b[7:0];
      r.bbuf = b >> 8;
      r.cnt  = c - 6'd8;
    end else begin
      r.sym  = {2'b0, b[5:0]};
      r.bbuf = b >> 6;
      r.cnt  = c - 6'd6;
    end
    return r;
  endfunction

endpackage

>>> hdl/bpe_ram.sv
// ----------------------------------------------------------------------------
// bpe_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bpe_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/byte_pair_expander_core.sv
// Supply and start items are handled directly in the wait state. A pull works through the
// decode steps (table symbol, count symbol, block boundary), the skipped literal entries, a
// stack pop, the pushed pairs and the last left link, then loads the output register. The
// table and stack RAMs have a registered read port; a waiting result holds the sequencer
// and stalls the input.
// Reset is synchronous: control state clears at once, the RAMs are not cleared.
// ----------------------------------------------------------------------------
// byte_pair_expander_core
// Byte-pair expander: table load, symbol count and stack-based expansion.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module byte_pair_expander_core #(
  parameter int TABLE_SIZE  = 256,
  parameter int STACK_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bpe_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output bpe_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_data
);

  import bpe_pkg::*;

  localparam int TAW = $clog2(TABLE_SIZE);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  logic            wide_r;
  logic [23:0]     count_r;
  logic [31:0]     bbuf_r, bbuf_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic [15:0]     held_r, held_nxt;
  logic            hv_r, hv_nxt;
  logic [23:0]     wr_r, wr_nxt;
  logic [SPW-1:0]  sp_r, sp_nxt;
  logic [8:0]      fill_r, fill_nxt;
  logic [8:0]      pairs_r, pairs_nxt;
  logic [16:0]     syms_r, syms_nxt;
  logic [7:0]      rem_r, rem_nxt;
  logic [7:0]      s_r, s_nxt;
  phase_t          phase_r, phase_nxt;
  ctl_t            ctl_r, ctl_nxt;
  out_item_t       res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;

  // memory ports
  logic            lt_we, rt_we, st_we, tbl_re, st_re;
  logic [TAW-1:0]  lt_waddr, rt_waddr, tbl_raddr;
  logic [7:0]      lt_wdata, rt_wdata, st_wdata;
  logic [SAW-1:0]  st_waddr, st_raddr;
  logic [7:0]      lt_rd, rt_rd, st_rd;

  logic [8:0]      span;
  logic [7:0]      half_m1;
  take_t           tk;
  logic            take_en;
  logic [26:0]     need;
  logic [23:0]     need_b;
  logic            done_chk;
  logic [8:0]      fp_pairs, fp_fill;
  phase_t          fp_phase;
  logic [SPW-1:0]  sp_dec;
  logic            out_free;
  logic            in_acc;

  function automatic logic ok_idx(logic [8:0] idx, logic [8:0] sp_n);
    return (idx < sp_n) && (idx < 9'(TABLE_SIZE));
  endfunction

  bpe_ram #(.DEPTH(TABLE_SIZE), .WIDTH(8)) u_left (
    .clk, .we(lt_we), .waddr(lt_waddr), .wdata(lt_wdata),
    .re(tbl_re), .raddr(tbl_raddr), .rdata(lt_rd)
  );

  bpe_ram #(.DEPTH(TABLE_SIZE), .WIDTH(8)) u_right (
    .clk, .we(rt_we), .waddr(rt_waddr), .wdata(rt_wdata),
    .re(tbl_re), .raddr(tbl_raddr), .rdata(rt_rd)
  );

  bpe_ram #(.DEPTH(STACK_DEPTH), .WIDTH(8)) u_stack (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .re(st_re), .raddr(st_raddr), .rdata(st_rd)
  );

  assign in_stall  = (ctl_r != C_WAIT);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  // symbol geometry
  assign span    = wide_r ? 9'd256 : 9'd64;
  assign half_m1 = wide_r ? 8'd127 : 8'd31;
  assign tk      = take_symbol(bbuf_r, cnt_r, held_r, hv_r, wide_r);

  // input size in bytes against bytes read so far
  assign need     = wide_r ? {count_r, 3'b0} : ({1'b0, count_r, 2'b0} + {2'b0, count_r, 1'b0});
  assign need_b   = need[26:3];
  assign done_chk = ({wr_r, 1'b0} >= {1'b0, need_b});

  // end of one pair
  always_comb begin
    fp_pairs = pairs_r - 9'd1;
    fp_fill  = fill_r + 9'd1;
    if (fp_pairs != 9'd0) begin
      fp_phase = PH_LEFT;
    end else if (fp_fill == span) begin
      fp_phase = PH_COUNT;
    end else begin
      fp_phase = PH_HEAD;
    end
  end

  assign sp_dec = sp_r - SPW'(1);

  // sequencer
  always_comb begin
    bbuf_nxt      = bbuf_r;
    cnt_nxt       = cnt_r;
    held_nxt      = held_r;
    hv_nxt        = hv_r;
    wr_nxt        = wr_r;
    sp_nxt        = sp_r;
    fill_nxt      = fill_r;
    pairs_nxt     = pairs_r;
    syms_nxt      = syms_r;
    rem_nxt       = rem_r;
    s_nxt         = s_r;
    phase_nxt     = phase_r;
    ctl_nxt       = ctl_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    take_en       = 1'b0;
    lt_we         = 1'b0;
    lt_waddr      = fill_r[TAW-1:0];
    lt_wdata      = tk.sym;
    rt_we         = 1'b0;
    rt_waddr      = fill_r[TAW-1:0];
    rt_wdata      = tk.sym;
    st_we         = 1'b0;
    st_waddr      = sp_r[SAW-1:0];
    st_wdata      = rt_rd;
    st_re         = 1'b0;
    st_raddr      = sp_dec[SAW-1:0];
    tbl_re        = 1'b0;
    tbl_raddr     = tk.sym[TAW-1:0];

    unique case (ctl_r)
      C_WAIT: begin
        if (in_acc) begin
          case (in_item.func)
            FUNC_SUPPLY: begin
              held_nxt = in_item.word;
              hv_nxt   = 1'b1;
            end
            FUNC_START: begin
              bbuf_nxt  = '0;
              cnt_nxt   = '0;
              hv_nxt    = 1'b0;
              wr_nxt    = '0;
              sp_nxt    = '0;
              fill_nxt  = '0;
              pairs_nxt = '0;
              syms_nxt  = '0;
              phase_nxt = (need_b == 24'd0) ? PH_DONE : PH_HEAD;
            end
            FUNC_PULL: begin
              ctl_nxt = C_RUN;
            end
            default: begin
            end
          endcase
        end
      end

      C_RUN: begin
        unique case (phase_r)
          PH_HEAD: begin
            take_en = 1'b1;
            if (!tk.ok) begin
              res_nxt = '{kind: KIND_NEED, out_byte: 8'd0};
              ctl_nxt = C_EMIT;
            end else if (tk.sym > half_m1) begin
              rem_nxt = tk.sym - half_m1;
              ctl_nxt = C_SKIP;
            end else if (fill_r == span) begin
              phase_nxt = PH_COUNT;
              pairs_nxt = 9'd1;
            end else begin
              pairs_nxt = {1'b0, tk.sym} + 9'd1;
              phase_nxt = PH_LEFT;
            end
          end
          PH_LEFT: begin
            if (!ok_idx(fill_r, span)) begin
              phase_nxt = PH_ERROR;
              res_nxt   = '{kind: KIND_ERROR, out_byte: 8'd0};
              ctl_nxt   = C_EMIT;
            end else begin
              take_en = 1'b1;
              if (!tk.ok) begin
                res_nxt = '{kind: KIND_NEED, out_byte: 8'd0};
                ctl_nxt = C_EMIT;
              end else begin
                lt_we = 1'b1;
                if ({1'b0, tk.sym} != fill_r) begin
                  phase_nxt = PH_RIGHT;
                end else begin
                  pairs_nxt = (fp_phase == PH_COUNT) ? 9'd1 : fp_pairs;
                  fill_nxt  = fp_fill;
                  phase_nxt = fp_phase;
                end
              end
            end
          end
          PH_RIGHT: begin
            take_en = 1'b1;
            if (!tk.ok) begin
              res_nxt = '{kind: KIND_NEED, out_byte: 8'd0};
              ctl_nxt = C_EMIT;
            end else begin
              rt_we     = 1'b1;
              pairs_nxt = (fp_phase == PH_COUNT) ? 9'd1 : fp_pairs;
              fill_nxt  = fp_fill;
              phase_nxt = fp_phase;
            end
          end
          PH_COUNT: begin
            take_en = 1'b1;
            if (!tk.ok) begin
              res_nxt = '{kind: KIND_NEED, out_byte: 8'd0};
              ctl_nxt = C_EMIT;
            end else if (pairs_r == 9'd1) begin
              syms_nxt  = wide_r ? {1'b0, tk.sym, 8'b0} : {3'b0, tk.sym, 6'b0};
              pairs_nxt = 9'd0;
            end else begin
              syms_nxt  = syms_r + {9'b0, tk.sym};
              sp_nxt    = '0;
              phase_nxt = PH_DECODE;
            end
          end
          PH_DECODE: begin
            if (sp_r != '0) begin
              // pop the next pending right symbol
              sp_nxt  = sp_dec;
              st_re   = 1'b1;
              ctl_nxt = C_POP;
            end else if (syms_r == 17'd0) begin
              // block boundary
              if (done_chk) begin
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_HEAD;
                fill_nxt  = '0;
              end
            end else begin
              take_en = 1'b1;
              if (!tk.ok) begin
                res_nxt = '{kind: KIND_NEED, out_byte: 8'd0};
                ctl_nxt = C_EMIT;
              end else begin
                syms_nxt = syms_r - 17'd1;
                if (!ok_idx({1'b0, tk.sym}, span)) begin
                  phase_nxt = PH_ERROR;
                  res_nxt   = '{kind: KIND_ERROR, out_byte: 8'd0};
                  ctl_nxt   = C_EMIT;
                end else begin
                  tbl_re  = 1'b1;
                  s_nxt   = tk.sym;
                  ctl_nxt = C_CHASE;
                end
              end
            end
          end
          PH_ERROR: begin
            res_nxt = '{kind: KIND_ERROR, out_byte: 8'd0};
            ctl_nxt = C_EMIT;
          end
          default: begin
            res_nxt = '{kind: KIND_DONE, out_byte: 8'd0};
            ctl_nxt = C_EMIT;
          end
        endcase
      end

      // literal entries map to themselves
      C_SKIP: begin
        if (rem_r == 8'd0) begin
          pairs_nxt = 9'd1;
          phase_nxt = (fill_r == span) ? PH_COUNT : PH_LEFT;
          ctl_nxt   = C_RUN;
        end else if (!ok_idx(fill_r, span)) begin
          phase_nxt = PH_ERROR;
          res_nxt   = '{kind: KIND_ERROR, out_byte: 8'd0};
          ctl_nxt   = C_EMIT;
        end else begin
          lt_we    = 1'b1;
          lt_wdata = fill_r[7:0];
          fill_nxt = fill_r + 9'd1;
          rem_nxt  = rem_r - 8'd1;
        end
      end

      // popped symbol starts a new expansion
      C_POP: begin
        if (!ok_idx({1'b0, st_rd}, span)) begin
          phase_nxt = PH_ERROR;
          res_nxt   = '{kind: KIND_ERROR, out_byte: 8'd0};
          ctl_nxt   = C_EMIT;
        end else begin
          tbl_re    = 1'b1;
          tbl_raddr = st_rd[TAW-1:0];
          s_nxt     = st_rd;
          ctl_nxt   = C_CHASE;
        end
      end

      // follow left links, pushing right symbols
      C_CHASE: begin
        if (lt_rd == s_r) begin
          res_nxt = '{kind: KIND_BYTE, out_byte: s_r};
          ctl_nxt = C_EMIT;
        end else if (sp_r >= SPW'(STACK_DEPTH)) begin
          phase_nxt = PH_ERROR;
          res_nxt   = '{kind: KIND_ERROR, out_byte: 8'd0};
          ctl_nxt   = C_EMIT;
        end else begin
          st_we  = 1'b1;
          sp_nxt = sp_r + SPW'(1);
          s_nxt  = lt_rd;
          if (!ok_idx({1'b0, lt_rd}, span)) begin
            phase_nxt = PH_ERROR;
            res_nxt   = '{kind: KIND_ERROR, out_byte: 8'd0};
            ctl_nxt   = C_EMIT;
          end else begin
            tbl_re    = 1'b1;
            tbl_raddr = lt_rd[TAW-1:0];
          end
        end
      end

      C_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          ctl_nxt       = C_WAIT;
        end
      end

      default: begin
        ctl_nxt = C_WAIT;
      end
    endcase

    // commit a consumed symbol to the bit reader
    if (take_en && tk.ok) begin
      bbuf_nxt = tk.bbuf;
      cnt_nxt  = tk.cnt;
      if (tk.used) begin
        hv_nxt = 1'b0;
        if (wr_r != 24'hFF_FFFF) begin
          wr_nxt = wr_r + 24'd1;
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r  <= 1'b1;
      count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_WIDE) begin
        wide_r <= cfg_data[0];
      end else begin
        count_r <= cfg_data;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bbuf_r      <= '0;
      cnt_r       <= '0;
      held_r      <= '0;
      hv_r        <= 1'b0;
      wr_r        <= '0;
      sp_r        <= '0;
      fill_r      <= '0;
      pairs_r     <= '0;
      syms_r      <= '0;
      phase_r     <= PH_IDLE;
      ctl_r       <= C_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      bbuf_r      <= bbuf_nxt;
      cnt_r       <= cnt_nxt;
      held_r      <= held_nxt;
      hv_r        <= hv_nxt;
      wr_r        <= wr_nxt;
      sp_r        <= sp_nxt;
      fill_r      <= fill_nxt;
      pairs_r     <= pairs_nxt;
      syms_r      <= syms_nxt;
      phase_r     <= phase_nxt;
      ctl_r       <= ctl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    s_r   <= s_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  // checks
  `BPE_ASSERT_ALWAYS(a_sp_bound, sp_r <= SPW'(STACK_DEPTH))
  `BPE_ASSERT_ALWAYS(a_fill_bound, fill_r <= 9'(TABLE_SIZE))
  `BPE_ASSERT_NEXT(a_emit_loads, (ctl_r == C_EMIT) && out_free, out_valid_r)
  `BPE_ASSERT_NEXT(a_pull_runs, in_acc && (in_item.func == FUNC_PULL), ctl_r == C_RUN)

endmodule
